// ----- hdl/a2bc_pkg.sv -----
`default_nettype none
package a2bc_pkg;

	localparam int WORD_W = 64;
	localparam int WORDS = 128;
	localparam int ADDR_W = 7;

	localparam logic [5:0] PAIR_LAST = 6'd63;
	localparam logic [4:0] GATHER_END = 5'd16;
	localparam logic [4:0] SCATTER_LAST = 5'd15;
	localparam logic [3:0] PH_ROT = 4'd8;
	localparam logic [2:0] Q_DIAG = 3'd3;
	localparam logic [2:0] Q_LAST = 3'd7;
	localparam logic [3:0] PERM_LAST = 4'd15;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_WR_E,
		S_WR_O,
		S_GATHER,
		S_ROUND,
		S_DIAG,
		S_UNDIAG,
		S_SCATTER,
		S_OUT_E,
		S_OUT_O,
		S_OUT_L,
		S_OUT_V
	} state_t;

	// operations on the 4x4 working word array
	typedef enum logic [2:0] {
		V_HOLD,
		V_SHIFT,
		V_G,
		V_ROT,
		V_DIAG,
		V_UNDIAG
	} vop_t;

	typedef struct packed {
		logic              in_ready;
		logic              out_valid;
		logic              item_wr;
		logic              item_odd;
		logic              work_we_v;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		vop_t              vop;
		logic [2:0]        g_ph;
		logic              cap_even;
		logic              load_out;
		logic              out_last;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_ready;
	} stat_t;

	// word address of element i of permutation p (rows first, then column groups)
	function automatic logic [ADDR_W-1:0] perm_addr(input logic [3:0] p, input logic [3:0] i);
		logic [ADDR_W-1:0] a;
		if (!p[3]) begin
			a = {p[2:0], i};
		end else begin
			a = {i[3:1], p[2:0], i[0]};
		end
		return a;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/a2bc_in_if.sv -----
`default_nettype none
interface a2bc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] x_even;
	logic [63:0] x_odd;
	logic [63:0] y_even;
	logic [63:0] y_odd;

	modport source (output valid, output x_even, output x_odd, output y_even, output y_odd,
		input ready);
	modport sink (input valid, input x_even, input x_odd, input y_even, input y_odd,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/a2bc_out_if.sv -----
`default_nettype none
interface a2bc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_even;
	logic [63:0] out_odd;
	logic        last_pair;

	modport source (output valid, output out_even, output out_odd, output last_pair,
		input ready);
	modport sink (input valid, input out_even, input out_odd, input last_pair,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/argon2_block_compression_core.sv -----
`default_nettype none
// Argon2 block compression G with the BlaMka round.
// item: 64 transactions, each carrying words 2k and 2k+1 of blocks X and Y,
// pair 0 first. Each input transaction is captured and then written as two
// words over the single write port of the stores before the next is taken.
// After the 64th input transaction the core runs 16 permutations (8 rows,
// then 8 column groups) through one shared BlaMka unit with one 32x32
// multiplier: each permutation gathers 16 words, runs 8 quarter rounds with
// a diagonal and an undiagonal shuffle, and writes its 16 words back.
// result: 64 transactions of two output words each, last_pair set on the
// final one. Each result takes two store reads, a load and the handshake;
// the result is held as long as result.ready stays low.
// No input transaction is taken from the 64th load of a block until the
// last result transaction completes.
// Reset clears the controller and the pair counter; the stores need no
// clearing since every word is written before it is read.
module argon2_block_compression_core (
	input  wire logic clk,
	input  wire logic arst_n,
	a2bc_in_if.sink   item,
	a2bc_out_if.source result
);

	a2bc_pkg::cmd_t  cmd;
	a2bc_pkg::stat_t stat;

	assign stat.in_valid  = item.valid;
	assign stat.out_ready = result.ready;
	assign item.ready     = cmd.in_ready;
	assign result.valid   = cmd.out_valid;

	a2bc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	a2bc_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.in_fire   (item.valid & cmd.in_ready),
		.x_even    (item.x_even),
		.x_odd     (item.x_odd),
		.y_even    (item.y_even),
		.y_odd     (item.y_odd),
		.out_even  (result.out_even),
		.out_odd   (result.out_odd),
		.last_pair (result.last_pair)
	);

endmodule
`default_nettype wire

// ----- hdl/a2bc_ram.sv -----
`default_nettype none
module a2bc_ram #(
	parameter int WIDTH = a2bc_pkg::WORD_W,
	parameter int DEPTH = a2bc_pkg::WORDS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/a2bc_ctrl.sv -----
`default_nettype none
module a2bc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire a2bc_pkg::stat_t stat,
	output a2bc_pkg::cmd_t       cmd
);

	a2bc_pkg::state_t state_q, state_d;
	logic [5:0] k_q;
	logic [4:0] cnt_q;
	logic [3:0] p_q;
	logic [2:0] q_q;
	logic [3:0] ph_q;
	logic [5:0] j_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= a2bc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cnt_q <= '0;
			p_q   <= '0;
			q_q   <= '0;
			ph_q  <= '0;
			j_q   <= '0;
		end else begin
			case (state_q)
				a2bc_pkg::S_WR_O: begin
					k_q   <= k_q + 6'd1;
					cnt_q <= '0;
					p_q   <= '0;
				end
				a2bc_pkg::S_GATHER: begin
					cnt_q <= cnt_q + 5'd1;
					q_q   <= '0;
					ph_q  <= '0;
				end
				a2bc_pkg::S_ROUND: begin
					if (ph_q == a2bc_pkg::PH_ROT) begin
						ph_q <= '0;
						if (q_q != a2bc_pkg::Q_LAST) begin
							q_q <= q_q + 3'd1;
						end
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				a2bc_pkg::S_UNDIAG: begin
					cnt_q <= '0;
				end
				a2bc_pkg::S_SCATTER: begin
					if (cnt_q == a2bc_pkg::SCATTER_LAST) begin
						cnt_q <= '0;
						p_q   <= p_q + 4'd1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
					j_q <= '0;
				end
				a2bc_pkg::S_OUT_V: begin
					if (stat.out_ready) begin
						j_q <= j_q + 6'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			a2bc_pkg::S_IDLE: begin
				if (stat.in_valid) begin
					state_d = a2bc_pkg::S_WR_E;
				end
			end
			a2bc_pkg::S_WR_E: begin
				state_d = a2bc_pkg::S_WR_O;
			end
			a2bc_pkg::S_WR_O: begin
				state_d = (k_q == a2bc_pkg::PAIR_LAST) ? a2bc_pkg::S_GATHER : a2bc_pkg::S_IDLE;
			end
			a2bc_pkg::S_GATHER: begin
				if (cnt_q == a2bc_pkg::GATHER_END) begin
					state_d = a2bc_pkg::S_ROUND;
				end
			end
			a2bc_pkg::S_ROUND: begin
				if (ph_q == a2bc_pkg::PH_ROT) begin
					if (q_q == a2bc_pkg::Q_DIAG) begin
						state_d = a2bc_pkg::S_DIAG;
					end else if (q_q == a2bc_pkg::Q_LAST) begin
						state_d = a2bc_pkg::S_UNDIAG;
					end
				end
			end
			a2bc_pkg::S_DIAG: begin
				state_d = a2bc_pkg::S_ROUND;
			end
			a2bc_pkg::S_UNDIAG: begin
				state_d = a2bc_pkg::S_SCATTER;
			end
			a2bc_pkg::S_SCATTER: begin
				if (cnt_q == a2bc_pkg::SCATTER_LAST) begin
					state_d = (p_q == a2bc_pkg::PERM_LAST) ? a2bc_pkg::S_OUT_E
						: a2bc_pkg::S_GATHER;
				end
			end
			a2bc_pkg::S_OUT_E: begin
				state_d = a2bc_pkg::S_OUT_O;
			end
			a2bc_pkg::S_OUT_O: begin
				state_d = a2bc_pkg::S_OUT_L;
			end
			a2bc_pkg::S_OUT_L: begin
				state_d = a2bc_pkg::S_OUT_V;
			end
			a2bc_pkg::S_OUT_V: begin
				if (stat.out_ready) begin
					state_d = (j_q == a2bc_pkg::PAIR_LAST) ? a2bc_pkg::S_IDLE
						: a2bc_pkg::S_OUT_E;
				end
			end
			default: begin
				state_d = a2bc_pkg::S_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.vop = a2bc_pkg::V_HOLD;
		case (state_q)
			a2bc_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			a2bc_pkg::S_WR_E: begin
				cmd.item_wr = 1'b1;
				cmd.waddr   = {k_q, 1'b0};
			end
			a2bc_pkg::S_WR_O: begin
				cmd.item_wr  = 1'b1;
				cmd.item_odd = 1'b1;
				cmd.waddr    = {k_q, 1'b1};
			end
			a2bc_pkg::S_GATHER: begin
				cmd.raddr = a2bc_pkg::perm_addr(p_q, cnt_q[3:0]);
				cmd.vop   = (cnt_q != '0) ? a2bc_pkg::V_SHIFT : a2bc_pkg::V_HOLD;
			end
			a2bc_pkg::S_ROUND: begin
				cmd.vop  = (ph_q == a2bc_pkg::PH_ROT) ? a2bc_pkg::V_ROT : a2bc_pkg::V_G;
				cmd.g_ph = ph_q[2:0];
			end
			a2bc_pkg::S_DIAG: begin
				cmd.vop = a2bc_pkg::V_DIAG;
			end
			a2bc_pkg::S_UNDIAG: begin
				cmd.vop = a2bc_pkg::V_UNDIAG;
			end
			a2bc_pkg::S_SCATTER: begin
				cmd.work_we_v = 1'b1;
				cmd.waddr     = a2bc_pkg::perm_addr(p_q, cnt_q[3:0]);
				cmd.vop       = a2bc_pkg::V_SHIFT;
			end
			a2bc_pkg::S_OUT_E: begin
				cmd.raddr = {j_q, 1'b0};
			end
			a2bc_pkg::S_OUT_O: begin
				cmd.raddr    = {j_q, 1'b1};
				cmd.cap_even = 1'b1;
			end
			a2bc_pkg::S_OUT_L: begin
				cmd.load_out = 1'b1;
				cmd.out_last = (j_q == a2bc_pkg::PAIR_LAST);
			end
			a2bc_pkg::S_OUT_V: begin
				cmd.out_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_not_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.in_ready && cmd.out_valid)) else $error("input and output both open");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q <= a2bc_pkg::PH_ROT) else $error("round phase out of range");
	a_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == a2bc_pkg::S_OUT_V && stat.out_ready && j_q == a2bc_pkg::PAIR_LAST)
		|=> state_q == a2bc_pkg::S_IDLE) else $error("no return to idle after last pair");
	a_work_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.item_wr || cmd.work_we_v) |-> (state_q == a2bc_pkg::S_WR_E
		|| state_q == a2bc_pkg::S_WR_O || state_q == a2bc_pkg::S_SCATTER))
		else $error("work store written in wrong state");
`endif

endmodule
`default_nettype wire

// ----- hdl/a2bc_dp.sv -----
`default_nettype none
module a2bc_dp (
	input  wire logic           clk,
	input  wire a2bc_pkg::cmd_t cmd,
	input  wire logic           in_fire,
	input  wire logic [63:0]    x_even,
	input  wire logic [63:0]    x_odd,
	input  wire logic [63:0]    y_even,
	input  wire logic [63:0]    y_odd,
	output logic      [63:0]    out_even,
	output logic      [63:0]    out_odd,
	output logic                last_pair
);

	logic [63:0] re_q, ro_q;
	logic [63:0] v_q [16];
	logic [63:0] prod_q;
	logic [63:0] even_q;
	logic [63:0] out_even_q, out_odd_q;
	logic        last_q;

	logic [63:0] item_word;
	logic [63:0] work_wdata, work_rdata, xor_rdata;
	logic        work_we;

	logic [31:0] mul_a, mul_b;
	logic [63:0] add_a, add_b, sum, d_mix, b_mix, d_rot, b_rot;

	// capture the xor of the incoming pair
	always_ff @(posedge clk) begin
		if (in_fire) begin
			re_q <= x_even ^ y_even;
			ro_q <= x_odd ^ y_odd;
		end
	end

	assign item_word  = cmd.item_odd ? ro_q : re_q;
	assign work_we    = cmd.item_wr | cmd.work_we_v;
	assign work_wdata = cmd.work_we_v ? v_q[0] : item_word;

	a2bc_ram #(.WIDTH(a2bc_pkg::WORD_W), .DEPTH(a2bc_pkg::WORDS)) u_xor_ram (
		.clk   (clk),
		.we    (cmd.item_wr),
		.waddr (cmd.waddr),
		.wdata (item_word),
		.raddr (cmd.raddr),
		.rdata (xor_rdata)
	);

	a2bc_ram #(.WIDTH(a2bc_pkg::WORD_W), .DEPTH(a2bc_pkg::WORDS)) u_work_ram (
		.clk   (clk),
		.we    (work_we),
		.waddr (cmd.waddr),
		.wdata (work_wdata),
		.raddr (cmd.raddr),
		.rdata (work_rdata)
	);

	// shared blamka unit on fixed slots a=0, b=4, c=8, d=12
	assign mul_a = cmd.g_ph[1] ? v_q[8][31:0] : v_q[0][31:0];
	assign mul_b = cmd.g_ph[1] ? v_q[12][31:0] : v_q[4][31:0];
	assign add_a = cmd.g_ph[1] ? v_q[8] : v_q[0];
	assign add_b = cmd.g_ph[1] ? v_q[12] : v_q[4];
	assign sum   = add_a + add_b + {prod_q[62:0], 1'b0};
	assign d_mix = v_q[12] ^ sum;
	assign b_mix = v_q[4] ^ sum;
	assign d_rot = cmd.g_ph[2] ? {d_mix[15:0], d_mix[63:16]} : {d_mix[31:0], d_mix[63:32]};
	assign b_rot = cmd.g_ph[2] ? {b_mix[62:0], b_mix[63]} : {b_mix[23:0], b_mix[63:24]};

	// working array: shift chain, row rotations and quarter-round updates
	always_ff @(posedge clk) begin
		case (cmd.vop)
			a2bc_pkg::V_SHIFT: begin
				for (int i = 0; i < 15; i++) begin
					v_q[i] <= v_q[i+1];
				end
				v_q[15] <= work_rdata;
			end
			a2bc_pkg::V_ROT: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						v_q[4*r+j] <= v_q[4*r+((j+1)%4)];
					end
				end
			end
			a2bc_pkg::V_DIAG: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						v_q[4*r+j] <= v_q[4*r+((j+r)%4)];
					end
				end
			end
			a2bc_pkg::V_UNDIAG: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						v_q[4*r+j] <= v_q[4*r+((j+4-r)%4)];
					end
				end
			end
			a2bc_pkg::V_G: begin
				if (!cmd.g_ph[0]) begin
					prod_q <= 64'(mul_a) * 64'(mul_b);
				end else if (!cmd.g_ph[1]) begin
					v_q[0]  <= sum;
					v_q[12] <= d_rot;
				end else begin
					v_q[8] <= sum;
					v_q[4] <= b_rot;
				end
			end
			default: begin
			end
		endcase
	end

	// output pair register
	always_ff @(posedge clk) begin
		if (cmd.cap_even) begin
			even_q <= work_rdata ^ xor_rdata;
		end
		if (cmd.load_out) begin
			out_even_q <= even_q;
			out_odd_q  <= work_rdata ^ xor_rdata;
			last_q     <= cmd.out_last;
		end
	end

	assign out_even  = out_even_q;
	assign out_odd   = out_odd_q;
	assign last_pair = last_q;

endmodule
`default_nettype wire

// ----- verif/tb_argon2_block_compression_core.sv -----
`default_nettype none
module tb_argon2_block_compression_core;

	localparam int PAIRS = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 3000;
	localparam int HALF_BLOCK = 32;

	typedef struct {
		logic [63:0] even;
		logic [63:0] odd;
		logic        last;
	} out_pair_t;

	logic clk;
	logic arst_n;
	a2bc_in_if  item_ch ();
	a2bc_out_if result_ch ();

	argon2_block_compression_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor state
	logic [63:0] r_words [a2bc_pkg::WORDS];
	logic [63:0] z_words [a2bc_pkg::WORDS];
	logic [5:0]  pair_idx;
	out_pair_t   pending_pairs [$];
	int          mismatches;
	int          cycles;
	int          hold_request;

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_argon2_block_compression_core: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic logic [63:0] fma_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] lo;
		lo = {32'd0, a[31:0]} * {32'd0, b[31:0]};
		return a + b + (lo << 1);
	endfunction

	task automatic mix(inout logic [63:0] v [16], input int ia, input int ib,
		input int ic, input int id);
		logic [63:0] a, b, c, d;
		a = v[ia]; b = v[ib]; c = v[ic]; d = v[id];
		a = fma_add(a, b); d = rotr(d ^ a, 32);
		c = fma_add(c, d); b = rotr(b ^ c, 24);
		a = fma_add(a, b); d = rotr(d ^ a, 16);
		c = fma_add(c, d); b = rotr(b ^ c, 63);
		v[ia] = a; v[ib] = b; v[ic] = c; v[id] = d;
	endtask

	task automatic permute(inout logic [63:0] v [16]);
		mix(v, 0, 4, 8, 12);
		mix(v, 1, 5, 9, 13);
		mix(v, 2, 6, 10, 14);
		mix(v, 3, 7, 11, 15);
		mix(v, 0, 5, 10, 15);
		mix(v, 1, 6, 11, 12);
		mix(v, 2, 7, 8, 13);
		mix(v, 3, 4, 9, 14);
	endtask

	// rows, then column groups, then queue the 64 output pairs
	task automatic compress_block();
		logic [63:0] g [16];
		out_pair_t   p;
		for (int r = 0; r < 8; r++) begin
			for (int i = 0; i < 16; i++) g[i] = z_words[r*16 + i];
			permute(g);
			for (int i = 0; i < 16; i++) z_words[r*16 + i] = g[i];
		end
		for (int c = 0; c < 8; c++) begin
			for (int r = 0; r < 8; r++) begin
				g[2*r] = z_words[r*16 + 2*c];
				g[2*r+1] = z_words[r*16 + 2*c + 1];
			end
			permute(g);
			for (int r = 0; r < 8; r++) begin
				z_words[r*16 + 2*c] = g[2*r];
				z_words[r*16 + 2*c + 1] = g[2*r+1];
			end
		end
		for (int j = 0; j < PAIRS; j++) begin
			p.even = z_words[2*j] ^ r_words[2*j];
			p.odd = z_words[2*j+1] ^ r_words[2*j+1];
			p.last = (j == PAIRS - 1);
			pending_pairs.push_back(p);
		end
	endtask

	task automatic load_pair(input logic [63:0] xe, input logic [63:0] xo,
		input logic [63:0] ye, input logic [63:0] yo);
		r_words[2*pair_idx] = xe ^ ye;
		r_words[2*pair_idx+1] = xo ^ yo;
		z_words[2*pair_idx] = xe ^ ye;
		z_words[2*pair_idx+1] = xo ^ yo;
		if (pair_idx == a2bc_pkg::PAIR_LAST) compress_block();
		pair_idx = pair_idx + 6'd1;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	// send one transaction after a random gap
	task automatic send_item(input logic [63:0] xe, input logic [63:0] xo,
		input logic [63:0] ye, input logic [63:0] yo);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.x_even <= xe;
		item_ch.x_odd <= xo;
		item_ch.y_even <= ye;
		item_ch.y_odd <= yo;
		do @(posedge clk); while (!item_ch.ready);
		load_pair(xe, xo, ye, yo);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_random_items(input int n);
		for (int k = 0; k < n; k++)
			send_item(rand64(), rand64(), rand64(), rand64());
	endtask

	// result side: random stalls, an occasional long hold-off
	initial begin
		int w;
		out_pair_t want;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (hold_request > 0) begin
				w = hold_request;
				hold_request = 0;
			end
			if (w > 0) begin
				result_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (pending_pairs.size() == 0) begin
				report("unexpected transaction", result_ch.out_even, 64'd0);
			end else begin
				want = pending_pairs.pop_front();
				if (result_ch.out_even !== want.even)
					report("out_even", result_ch.out_even, want.even);
				if (result_ch.out_odd !== want.odd)
					report("out_odd", result_ch.out_odd, want.odd);
				if (result_ch.last_pair !== want.last)
					report("last_pair", {63'd0, result_ch.last_pair}, {63'd0, want.last});
			end
		end
	end

	// extreme words first, then patterned words, then random fill
	task automatic test_extremes();
		send_item('0, '0, '0, '0);
		send_item('1, '1, '0, '0);
		send_item('0, '0, '1, '1);
		send_item('1, '1, '1, '1);
		send_item({32{2'b10}}, {32{2'b01}}, {32{2'b01}}, {32{2'b10}});
		send_item(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
			64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000);
		for (int k = 6; k < PAIRS; k++) begin
			if (k < 20) send_item(64'(k) << k, 64'hffff_ffff_ffff_ffff >> k, '0,
				64'(1) << (63 - k));
			else send_item(rand64(), rand64(), rand64(), rand64());
		end
	endtask

	// results held off while the next block is offered
	task automatic test_backpressure();
		hold_request = LONG_HOLD;
		send_random_items(HALF_BLOCK);
	endtask

	// sender waits for every pending result before going on
	task automatic test_drain_pause();
		item_ch.valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		send_random_items(PAIRS - HALF_BLOCK);
	endtask

	initial begin
		clk = 1'b0;
		cycles = 0;
		mismatches = 0;
		hold_request = 0;
		pair_idx = '0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.x_even <= '0;
		item_ch.x_odd <= '0;
		item_ch.y_even <= '0;
		item_ch.y_odd <= '0;
		result_ch.ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_backpressure();
		test_drain_pause();

		item_ch.valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_argon2_block_compression_core: PASS");
		end else begin
			$display("tb_argon2_block_compression_core: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
